/* src/iee_pkg.sv */
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types, constants and character helpers of the infix evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int CNT_W      = $clog2(WORD_WIDTH);
	localparam int VALUE_W    = 32;

	localparam logic [7:0] CHAR_PLUS   = 8'h2b;
	localparam logic [7:0] CHAR_MINUS  = 8'h2d;
	localparam logic [7:0] CHAR_TIMES  = 8'h2a;
	localparam logic [7:0] CHAR_DIVIDE = 8'h2f;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_CR     = 8'h0d;

	typedef enum logic [2:0] {
		OP_PLUS   = 3'd0,
		OP_MINUS  = 3'd1,
		OP_TIMES  = 3'd2,
		OP_DIVIDE = 3'd3,
		OP_DROP   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_DIV,
		ST_DIV_FIX,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic take;      // input item accepted this cycle
		logic close;     // apply pending operator or start the divider
		logic div_step;  // one quotient bit
		logic div_fix;   // write signed quotient back to the term
		logic finish;    // load the result and clear the expression state
	} ctrl_cmd_t;

	typedef struct packed {
		logic close_req;   // incoming item closes the current number
		logic div_needed;  // pending divide with a nonzero divisor
		logic last;        // the closing item was the last of the expression
	} dp_status_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
	endfunction

	function automatic op_t op_of(input logic [7:0] c);
		op_t op;
		case (c)
			CHAR_PLUS:   op = OP_PLUS;
			CHAR_MINUS:  op = OP_MINUS;
			CHAR_TIMES:  op = OP_TIMES;
			CHAR_DIVIDE: op = OP_DIVIDE;
			default:     op = OP_DROP;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

/* src/iee_ctrl.sv */
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer of the evaluator: input handshake, close step, divider
// iterations, result hand-off and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  iee_pkg::dp_status_t  status,
	output iee_pkg::ctrl_cmd_t   cmd
);

	iee_pkg::state_t state_q, state_d;
	logic [iee_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iee_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			iee_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (status.close_req)
						state_d = iee_pkg::ST_CLOSE;
				end
			end
			iee_pkg::ST_CLOSE: begin
				cmd.close = 1'b1;
				cnt_d     = '0;
				if (status.div_needed)
					state_d = iee_pkg::ST_DIV;
				else if (status.last)
					state_d = iee_pkg::ST_FINISH;
				else
					state_d = iee_pkg::ST_IDLE;
			end
			iee_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == iee_pkg::CNT_W'(iee_pkg::WORD_WIDTH - 1))
					state_d = iee_pkg::ST_DIV_FIX;
			end
			iee_pkg::ST_DIV_FIX: begin
				cmd.div_fix = 1'b1;
				state_d     = status.last ? iee_pkg::ST_FINISH : iee_pkg::ST_IDLE;
			end
			iee_pkg::ST_FINISH: begin
				// wait here while the previous result is still unclaimed
				if (out_free) begin
					cmd.finish  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = iee_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iee_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/iee_dpath.sv */
// ----------------------------------------------------------------------------
// iee_dpath
// Datapath of the evaluator: number accumulator, term and sum registers,
// multiplier, restoring divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_dpath (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire  [7:0]                  char_code,
	input  wire                         is_last,
	input  iee_pkg::ctrl_cmd_t          cmd,
	output iee_pkg::dp_status_t         status,
	output logic signed [31:0]          value,
	output logic                        div_zero
);

	localparam int W = iee_pkg::WORD_WIDTH;

	logic [W-1:0]    term_sum_q, cur_term_q, num_acc_q;
	iee_pkg::op_t    pend_op_q, new_op_q;
	logic            last_q, err_q;
	logic [W-1:0]    div_rem_q, div_quo_q, div_den_q;
	logic            div_neg_q;
	logic signed [31:0] value_q;
	logic            div_zero_q;

	logic [W-1:0] acc_next;
	logic [W:0]   shifted, trial;
	logic [W-1:0] quotient;
	logic [W-1:0] res_word;

	assign acc_next = (num_acc_q << 3) + (num_acc_q << 1)
		+ W'(char_code - iee_pkg::CHAR_ZERO);

	assign status.close_req  = !(iee_pkg::is_digit(char_code) || iee_pkg::is_space(char_code))
		|| is_last;
	assign status.div_needed = (pend_op_q == iee_pkg::OP_DIVIDE) && (num_acc_q != '0);
	assign status.last       = last_q;

	// one restoring step: shift in the next dividend bit, keep if it fits
	assign shifted  = {div_rem_q, div_quo_q[W-1]};
	assign trial    = shifted - {1'b0, div_den_q};
	assign quotient = div_neg_q ? (W'(0) - div_quo_q) : div_quo_q;
	assign res_word = term_sum_q + cur_term_q;

	assign value    = value_q;
	assign div_zero = div_zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_sum_q <= '0;
			cur_term_q <= '0;
			num_acc_q  <= '0;
			pend_op_q  <= iee_pkg::OP_PLUS;
			new_op_q   <= iee_pkg::OP_PLUS;
			last_q     <= 1'b0;
			err_q      <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (iee_pkg::is_digit(char_code))
					num_acc_q <= acc_next;
				new_op_q <= iee_pkg::op_of(char_code);
				last_q   <= is_last;
			end
			if (cmd.close && !status.div_needed) begin
				case (pend_op_q)
					iee_pkg::OP_PLUS: begin
						term_sum_q <= term_sum_q + cur_term_q;
						cur_term_q <= num_acc_q;
					end
					iee_pkg::OP_MINUS: begin
						term_sum_q <= term_sum_q + cur_term_q;
						cur_term_q <= W'(0) - num_acc_q;
					end
					iee_pkg::OP_TIMES: begin
						cur_term_q <= W'(cur_term_q * num_acc_q);
					end
					iee_pkg::OP_DIVIDE: begin
						// divisor is zero here
						err_q      <= 1'b1;
						cur_term_q <= '0;
					end
					default: begin
					end
				endcase
				num_acc_q <= '0;
				pend_op_q <= new_op_q;
			end
			if (cmd.div_fix) begin
				cur_term_q <= quotient;
				num_acc_q  <= '0;
				pend_op_q  <= new_op_q;
			end
			if (cmd.finish) begin
				term_sum_q <= '0;
				cur_term_q <= '0;
				num_acc_q  <= '0;
				pend_op_q  <= iee_pkg::OP_PLUS;
				err_q      <= 1'b0;
				last_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close && status.div_needed) begin
			div_rem_q <= '0;
			div_quo_q <= cur_term_q[W-1] ? (W'(0) - cur_term_q) : cur_term_q;
			div_den_q <= num_acc_q[W-1] ? (W'(0) - num_acc_q) : num_acc_q;
			div_neg_q <= cur_term_q[W-1] ^ num_acc_q[W-1];
		end else if (cmd.div_step) begin
			if (!trial[W]) begin
				div_rem_q <= trial[W-1:0];
				div_quo_q <= {div_quo_q[W-2:0], 1'b1};
			end else begin
				div_rem_q <= shifted[W-1:0];
				div_quo_q <= {div_quo_q[W-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			value_q    <= iee_pkg::VALUE_W'(signed'(res_word));
			div_zero_q <= err_q;
		end
	end

endmodule

`default_nettype wire

/* src/infix_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Streaming evaluator of ASCII infix expressions with + - * / on integers.
// ----------------------------------------------------------------------------
// Usage: characters enter on the input channel (in_valid / in_ready, with
// char_code and is_last), one item per handshake. A digit or white space
// that is not last keeps the input ready. A character that closes a number
// runs the close step; closing a division with a nonzero divisor also runs
// the restoring divider, one quotient bit per cycle, and its sign fix-up
// step. The last character adds the finish step that loads the result
// register, so out_valid rises on the output channel (out_valid /
// out_ready, with value and div_zero) once the close step, any division
// and the finish step are through. The result sits in an output register:
// new characters are taken while it waits. If the receiver still holds off
// when the next expression is finished, the block waits with in_ready low
// until the result is taken.
// Reset clears the expression state and the output valid flag; after each
// result the expression state returns to its reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_expression_evaluator (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          char_code,
	input  wire                 is_last,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic signed [31:0]  value,
	output logic                div_zero
);

	iee_pkg::ctrl_cmd_t  cmd;
	iee_pkg::dp_status_t status;

	iee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	iee_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (char_code),
		.is_last   (is_last),
		.cmd       (cmd),
		.status    (status),
		.value     (value),
		.div_zero  (div_zero)
	);

endmodule

`default_nettype wire

/* src/iee_checker.sv */
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               in_valid,
	input wire               in_ready,
	input wire  [7:0]        char_code,
	input wire               is_last,
	input wire               out_valid,
	input wire               out_ready,
	input wire signed [31:0] value,
	input wire               div_zero
);

	logic in_take, passes;

	assign in_take = in_valid && in_ready;
	assign passes  = !is_last && (iee_pkg::is_digit(char_code) || iee_pkg::is_space(char_code));

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value) && $stable(div_zero))
		else $error("result changed while stalled");

	// digits and spaces inside an expression leave the input ready
	a_digit_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && passes |=> in_ready)
		else $error("input not ready after digit or space");

	// a closing item keeps the input busy in the cycle after it is taken
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !passes |=> !in_ready)
		else $error("input ready right after a closing item");

	// a new result only comes out of the busy finish step
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while input was idle");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.char_code (char_code),
	.is_last   (is_last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value),
	.div_zero  (div_zero)
);

`default_nettype wire

/* tb/iee_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iee_result_checker
// Watches both channels of the infix evaluator, folds every accepted
// character into its own running sum and term, and compares each result
// item with the value it worked out for that expression.
// ----------------------------------------------------------------------------

module iee_result_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire                in_ready,
	input  wire  [7:0]         char_code,
	input  wire                is_last,
	input  wire                out_valid,
	input  wire                out_ready,
	input  wire  signed [31:0] value,
	input  wire                div_zero,
	output int                 fails,
	output int                 results_due
);

	localparam int W = iee_pkg::WORD_WIDTH;

	typedef logic [W-1:0] word_t;

	typedef struct {
		logic signed [31:0] value;
		logic               div_zero;
	} expr_result_t;

	expr_result_t expr_results[$];

	// evaluation state of the expression in progress
	word_t        sum_w;
	word_t        term_w;
	word_t        acc_w;
	iee_pkg::op_t pend_op;
	logic         err_seen;

	initial begin
		fails       = 0;
		results_due = 0;
		sum_w       = '0;
		term_w      = '0;
		acc_w       = '0;
		pend_op     = iee_pkg::OP_PLUS;
		err_seen    = 1'b0;
	end

	task automatic fold_char(input logic [7:0] c, input logic last);
		logic         digit;
		logic         blank;
		word_t        num_mag;
		word_t        den_mag;
		word_t        quot;
		word_t        total;
		expr_result_t res;
		digit = (c >= iee_pkg::CHAR_ZERO) && (c <= iee_pkg::CHAR_NINE);
		blank = (c == iee_pkg::CHAR_SPACE)
			|| ((c >= iee_pkg::CHAR_TAB) && (c <= iee_pkg::CHAR_CR));
		if (digit) begin
			acc_w = acc_w * word_t'(10) + word_t'(c - iee_pkg::CHAR_ZERO);
		end
		if ((!digit && !blank) || last) begin
			case (pend_op)
				iee_pkg::OP_PLUS: begin
					sum_w  = sum_w + term_w;
					term_w = acc_w;
				end
				iee_pkg::OP_MINUS: begin
					sum_w  = sum_w + term_w;
					term_w = -acc_w;
				end
				iee_pkg::OP_TIMES: begin
					term_w = term_w * acc_w;
				end
				iee_pkg::OP_DIVIDE: begin
					if (acc_w == '0) begin
						err_seen = 1'b1;
						term_w   = '0;
					end else begin
						// magnitudes as unsigned, so min / -1 wraps back to min
						num_mag = term_w[W-1] ? -term_w : term_w;
						den_mag = acc_w[W-1] ? -acc_w : acc_w;
						quot    = num_mag / den_mag;
						term_w  = (term_w[W-1] ^ acc_w[W-1]) ? -quot : quot;
					end
				end
				default: ;
			endcase
			acc_w = '0;
			case (c)
				iee_pkg::CHAR_PLUS:   pend_op = iee_pkg::OP_PLUS;
				iee_pkg::CHAR_MINUS:  pend_op = iee_pkg::OP_MINUS;
				iee_pkg::CHAR_TIMES:  pend_op = iee_pkg::OP_TIMES;
				iee_pkg::CHAR_DIVIDE: pend_op = iee_pkg::OP_DIVIDE;
				default:              pend_op = iee_pkg::OP_DROP;
			endcase
		end
		if (last) begin
			total        = sum_w + term_w;
			res.value    = $signed(total);
			res.div_zero = err_seen;
			expr_results.push_back(res);
			results_due++;
			sum_w    = '0;
			term_w   = '0;
			acc_w    = '0;
			pend_op  = iee_pkg::OP_PLUS;
			err_seen = 1'b0;
		end
	endtask

	always @(posedge clk) begin : watch
		expr_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expr_results.size() == 0) begin
					$error("result item with no expression pending: value %0d div_zero %0b",
						value, div_zero);
					fails++;
				end else begin
					want = expr_results.pop_front();
					results_due--;
					if (value !== want.value) begin
						$error("value: expected %0d, actual %0d", want.value, value);
						fails++;
					end
					if (div_zero !== want.div_zero) begin
						$error("div_zero: expected %0b, actual %0b", want.div_zero, div_zero);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				fold_char(char_code, is_last);
			end
		end
	end

endmodule

/* tb/tb_infix_expression_evaluator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_infix_expression_evaluator
// Feeds the evaluator a few hand-made expressions for the corner cases,
// then random expressions with noise characters, under three patterns of
// sender and receiver stalls; the checker beside the block scores results.
// ----------------------------------------------------------------------------

module tb_infix_expression_evaluator;

	localparam int CHAR_TARGET = 1000;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         char_code = '0;
	logic               is_last = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] value;
	logic               div_zero;

	int fails;
	int results_due;
	int send_idle_pct = 38;
	int recv_idle_pct = 75;
	int chars_sent = 0;
	int cycle_count = 0;

	logic [7:0] expr_chars[$];

	infix_expression_evaluator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.div_zero  (div_zero)
	);

	iee_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.div_zero    (div_zero),
		.fails       (fails),
		.results_due (results_due)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_infix_expression_evaluator: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		is_last   <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_expression();
		for (int i = 0; i < expr_chars.size(); i++) begin
			send_char(expr_chars[i], i == expr_chars.size() - 1);
		end
		expr_chars.delete();
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			expr_chars.push_back(s[i]);
		end
	endtask

	task automatic add_blanks();
		int pick;
		if ($urandom_range(3) == 0) begin
			pick = $urandom_range(5);
			expr_chars.push_back(pick == 0 ? iee_pkg::CHAR_SPACE
				: 8'(iee_pkg::CHAR_TAB + pick - 1));
		end
	endtask

	task automatic add_number(input logic zero_divisor);
		int ndig;
		if (zero_divisor) begin
			expr_chars.push_back(iee_pkg::CHAR_ZERO);
		end else begin
			ndig = ($urandom_range(9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
			repeat (ndig) expr_chars.push_back(8'(iee_pkg::CHAR_ZERO + $urandom_range(9)));
		end
	endtask

	task automatic build_expression();
		int         terms;
		logic [7:0] op_char;
		terms = $urandom_range(1, 6);
		if ($urandom_range(19) == 0) begin
			expr_chars.push_back(8'($urandom_range(255)));
		end
		add_blanks();
		add_number(1'b0);
		for (int k = 1; k < terms; k++) begin
			add_blanks();
			if ($urandom_range(9) == 0) begin
				// noise: any code, mostly an unknown operator
				op_char = 8'($urandom_range(255));
			end else begin
				case ($urandom_range(3))
					0:       op_char = iee_pkg::CHAR_PLUS;
					1:       op_char = iee_pkg::CHAR_MINUS;
					2:       op_char = iee_pkg::CHAR_TIMES;
					default: op_char = iee_pkg::CHAR_DIVIDE;
				endcase
			end
			expr_chars.push_back(op_char);
			add_blanks();
			add_number(op_char == iee_pkg::CHAR_DIVIDE && $urandom_range(4) == 0);
		end
		// sometimes end on a random code, mostly something other than a digit
		if ($urandom_range(11) == 0) begin
			expr_chars.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (results_due != 0) @(negedge clk);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// most negative word divided by a number that wraps to -1
		queue_text("2147483648/4294967295");
		send_expression();
		// divide by zero inside a sum
		queue_text("9-8/0");
		send_expression();
		// top code as unknown operator drops the number after it
		queue_text("3*4");
		expr_chars.push_back(8'hff);
		queue_text("5");
		send_expression();
		// code zero up front, white space, tab as the last character
		expr_chars.push_back(8'h00);
		queue_text("1+ 2\t");
		send_expression();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 38;
					recv_idle_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					recv_idle_pct = 38;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			while (chars_sent < (phase + 1) * CHAR_TARGET / 3) begin
				build_expression();
				send_expression();
			end
			// hold off until the block has handed over every result
			drain_results();
		end

		repeat (iee_pkg::WORD_WIDTH + 8) @(negedge clk);
		if (fails == 0 && results_due == 0) begin
			$display("tb_infix_expression_evaluator: clean");
		end else begin
			$display("tb_infix_expression_evaluator: errors");
		end
		$finish;
	end

endmodule
